@@ sv/ikef_pkg.sv @@
// ikef_pkg: shared types, constants and the frame prefix check
// used by the controller, the datapath and the top level of the frame extractor
`timescale 1ns / 1ps
`default_nettype none

package ikef_pkg;

    localparam int FRAME_LEN = 8;
    localparam int SYNC_LEN  = 4;
    localparam int LEN_W     = $clog2(FRAME_LEN + 1);

    localparam logic [31:0] SYNC_WORD_RESET = 32'hC06C57CC;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd1;
    localparam logic        FORWARD_RESET   = 1'b1;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SYNC_WORD      = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd1;
    localparam logic [1:0] REG_FORWARD_ENABLE = 2'd2;

    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_TICK   = 1'b1;
    localparam logic KIND_PASS = 1'b0;
    localparam logic KIND_KEY  = 1'b1;

    typedef logic [FRAME_LEN-1:0][7:0] frame_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic load_byte;
        logic tick_inc;
        logic idle_clr;
        logic shift;
        logic clr_len;
        logic load_pass;
        logic load_key;
    } cmd_t;

    typedef struct packed {
        logic len_zero;
        logic full;
        logic head_valid;
        logic shift_valid;
        logic timeout_hit;
    } status_t;

    // true when the first n bytes of b are the start of a well-formed frame
    function automatic logic prefix_valid(frame_t b, len_t n, logic [31:0] sync);
        logic       ok;
        logic [7:0] x;
        ok = 1'b1;
        x  = 8'd0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            x = x ^ b[i];
        end
        for (int i = 0; i < SYNC_LEN; i++) begin
            if ((n > len_t'(i)) && (b[i] != sync[31 - 8 * i -: 8])) begin
                ok = 1'b0;
            end
        end
        if ((n == len_t'(FRAME_LEN)) && (b[FRAME_LEN-1] != x)) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

@@ sv/ikef_datapath.sv @@
// ikef_datapath: byte hold buffer, idle tick counter, prefix checks and result register
// depends on ikef_pkg for the command and status structs and the prefix check
`timescale 1ns / 1ps
`default_nettype none

module ikef_datapath (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ikef_pkg::cmd_t   cmd,
    output ikef_pkg::status_t     status,
    input  wire logic [7:0]       rx_byte,
    input  wire logic [31:0]      sync_word,
    input  wire logic [15:0]      timeout_ticks,
    output logic                  m_kind,
    output logic [7:0]            m_pass_byte,
    output logic [7:0]            m_modifier,
    output logic [7:0]            m_key_first,
    output logic [7:0]            m_key_second,
    output logic                  m_last
);
    import ikef_pkg::*;

    frame_t      buf_reg;
    len_t        len_reg;
    logic [15:0] idle_reg;
    logic [15:0] idle_inc;
    logic [15:0] limit;
    frame_t      shifted;

    assign shifted  = buf_reg >> 8;
    assign idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign limit    = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;

    always_comb begin
        status.len_zero    = (len_reg == len_t'(0));
        status.full        = (len_reg == len_t'(FRAME_LEN));
        status.head_valid  = prefix_valid(buf_reg, len_reg, sync_word);
        status.shift_valid = prefix_valid(shifted, len_reg - len_t'(1), sync_word);
        status.timeout_hit = (idle_inc >= limit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            idle_reg <= '0;
        end else begin
            if (cmd.load_byte) begin
                len_reg <= len_reg + len_t'(1);
            end else if (cmd.shift) begin
                len_reg <= len_reg - len_t'(1);
            end else if (cmd.clr_len) begin
                len_reg <= '0;
            end
            if (cmd.load_byte || cmd.idle_clr) begin
                idle_reg <= '0;
            end else if (cmd.tick_inc) begin
                idle_reg <= idle_inc;
            end
        end
    end

    // held bytes carry no reset, only entries below the count are ever used
    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            buf_reg[len_reg[LEN_W-2:0]] <= rx_byte;
        end else if (cmd.shift) begin
            buf_reg <= shifted;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pass) begin
            m_kind       <= KIND_PASS;
            m_pass_byte  <= buf_reg[0];
            m_modifier   <= 8'd0;
            m_key_first  <= 8'd0;
            m_key_second <= 8'd0;
            m_last       <= status.shift_valid;
        end else if (cmd.load_key) begin
            m_kind       <= KIND_KEY;
            m_pass_byte  <= 8'd0;
            m_modifier   <= buf_reg[4];
            m_key_first  <= buf_reg[5];
            m_key_second <= buf_reg[6];
            m_last       <= 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ sv/ikef_ctrl.sv @@
// ikef_ctrl: state machine that accepts items, steps the rescan and owns result valid
// depends on ikef_pkg for the command and status structs and the operation codes
`timescale 1ns / 1ps
`default_nettype none

module ikef_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_operation,
    input  wire logic              m_ready,
    output logic                   m_valid,
    input  wire logic              forward_enable,
    input  wire ikef_pkg::status_t status,
    output ikef_pkg::cmd_t         cmd
);
    import ikef_pkg::*;

    typedef enum logic {ST_IDLE, ST_RESOLVE} state_t;

    state_t state_reg, state_next;
    logic   force_reg, force_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        force_next   = force_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_BYTE) begin
                        cmd.load_byte = 1'b1;
                        force_next    = 1'b0;
                        state_next    = ST_RESOLVE;
                    end else if (status.len_zero) begin
                        cmd.idle_clr = 1'b1;
                    end else if (status.timeout_hit) begin
                        // stale partial frame: release the oldest byte regardless
                        cmd.idle_clr = 1'b1;
                        force_next   = 1'b1;
                        state_next   = ST_RESOLVE;
                    end else begin
                        cmd.tick_inc = 1'b1;
                    end
                end
            end
            ST_RESOLVE: begin
                if (status.len_zero) begin
                    force_next = 1'b0;
                    state_next = ST_IDLE;
                end else if (status.head_valid && !force_reg) begin
                    if (!status.full) begin
                        state_next = ST_IDLE;
                    end else if (slot_free) begin
                        cmd.load_key = 1'b1;
                        cmd.clr_len  = 1'b1;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else if (!forward_enable) begin
                    cmd.shift  = 1'b1;
                    force_next = 1'b0;
                end else if (slot_free) begin
                    cmd.load_pass = 1'b1;
                    cmd.shift     = 1'b1;
                    m_valid_next  = 1'b1;
                    force_next    = 1'b0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            force_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            force_reg   <= force_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/inline_key_event_frame_extractor.sv @@
// flow: the idle state takes a transaction; a byte, or a tick that times out a partial
// frame, starts a rescan that releases held bytes oldest first, one per cycle, and ends by
// keeping the prefix, finding the buffer empty or loading a key event; other ticks stay idle
// s_ready is low during the rescan, so no new transaction is taken until it ends;
// a result stalls the rescan while the output register still holds the previous one
// reset: synchronous active low; clears hold count, idle ticks, handshake state; presets config
`timescale 1ns / 1ps
`default_nettype none

module inline_key_event_frame_extractor (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [7:0]       m_pass_byte,
    output logic [7:0]       m_modifier,
    output logic [7:0]       m_key_first,
    output logic [7:0]       m_key_second,
    output logic             m_last,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wr_data
);
    import ikef_pkg::*;

    logic [31:0] sync_word_reg;
    logic [15:0] timeout_ticks_reg;
    logic        forward_enable_reg;
    cmd_t        cmd;
    status_t     status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_word_reg      <= SYNC_WORD_RESET;
            timeout_ticks_reg  <= TIMEOUT_RESET;
            forward_enable_reg <= FORWARD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SYNC_WORD:      sync_word_reg      <= cfg_wr_data;
                REG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_wr_data[15:0];
                REG_FORWARD_ENABLE: forward_enable_reg <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    ikef_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .forward_enable (forward_enable_reg),
        .status         (status),
        .cmd            (cmd)
    );

    ikef_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .rx_byte       (s_rx_byte),
        .sync_word     (sync_word_reg),
        .timeout_ticks (timeout_ticks_reg),
        .m_kind        (m_kind),
        .m_pass_byte   (m_pass_byte),
        .m_modifier    (m_modifier),
        .m_key_first   (m_key_first),
        .m_key_second  (m_key_second),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire
